>>> src/stb_pkg.sv
// shared types, constants and controller/datapath interface for the timer bank
// no dependencies; imported by every module of the block but stb_ram
`default_nettype none

package stb_pkg;

  // field widths of one input item and one result item
  localparam int unsigned OP_W     = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned MS_W     = 22;
  localparam int unsigned OWNER_W  = 16;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned IV_W     = 31;
  localparam int unsigned MIN_W    = 20;
  localparam int unsigned PROD_W   = 32;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 24;

  // slot entry in the timer memory: {interval, owner, start}
  localparam int unsigned ENTRY_W = IV_W + OWNER_W + NOW_W;

  localparam int unsigned TIMER_SLOTS_DEF = 16;

  localparam logic [MIN_W-1:0] MIN_IV_RESET = 20'd1000;
  localparam logic [9:0]       US_PER_MS    = 10'd1000;
  localparam logic [IV_W-1:0]  INTERVAL_MAX = 31'h7FFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_CREATE  = 3'd1,
    OP_DESTROY = 3'd2,
    OP_START   = 3'd3,
    OP_STOP    = 3'd4,
    OP_MODE    = 3'd5
  } op_e;

  // input tdata, last field in the lowest bits
  typedef struct packed {
    logic [1:0]         pad;
    logic [NOW_W-1:0]   now_us;
    logic               has_handler;
    logic [MODE_W-1:0]  mode_flags;
    logic [OWNER_W-1:0] owner_tag;
    logic [MS_W-1:0]    interval_ms;
    logic [SLOT_W-1:0]  slot;
  } item_t;

  // output tdata, last field in the lowest bits
  typedef struct packed {
    logic [1:0]         pad;
    logic               ok;
    logic [OWNER_W-1:0] event_owner;
    logic               direct_call;
    logic [SLOT_W-1:0]  timer_index;
  } res_t;

  typedef enum logic [1:0] {
    RA_CNT  = 2'd0,
    RA_NEXT = 2'd1,
    RA_SLOT = 2'd2
  } rsel_e;

  typedef enum logic {
    WS_RELOAD = 1'b0,
    WS_CREATE = 1'b1
  } wsel_e;

  typedef enum logic [1:0] {
    IDX_ZERO = 2'd0,
    IDX_SLOT = 2'd1,
    IDX_CNT  = 2'd2
  } isel_e;

  typedef enum logic [2:0] {
    FL_NONE    = 3'd0,
    FL_CREATE  = 3'd1,
    FL_DESTROY = 3'd2,
    FL_START   = 3'd3,
    FL_STOP    = 3'd4,
    FL_MODE    = 3'd5,
    FL_DISABLE = 3'd6
  } flop_e;

  typedef struct packed {
    logic  capture;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  prod_load;
    logic  ival_load;
    logic  ram_re;
    rsel_e ram_rsel;
    logic  ram_we;
    wsel_e ram_wsel;
    logic  ram_wa_slot;
    flop_e flag_op;
    logic  out_load;
    logic  out_fire;
    logic  out_ok;
    isel_e out_isel;
  } stb_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            slot_valid;
    logic            ms_zero;
    logic            mode_en;
    logic            cnt_last;
    logic            cnt_free;
    logic            scan_hit;
    logic            scan_notify;
    logic            scan_repeat;
    logic            out_free;
  } stb_sts_t;

endpackage

`default_nettype wire

>>> src/software_timer_bank.sv
// Software timer bank: TIMER_SLOTS timer slots, each with an interval, a start
// time, an owner tag and flags (in use, enabled, auto-repeat, direct, handler).
// Each input beat is one command (tick, create, destroy, start, stop, set mode)
// with the current microsecond time, and each ends with one completion beat
// (tlast high). A tick walks the slots in index order, one slot per cycle out
// of the timer memory while no fire beat waits on m_axis_tready; a slot whose
// signed elapsed time reaches its interval sends a fire beat if it has a
// handler, then reloads or disables itself. Create runs the ms to us
// multiply, saturate and clamp, then the free-slot walk; start and set mode
// read the memory then write back, destroy and stop only update the flags.
// The input side is ready again as soon as the completion sits in the output
// register. min_interval_us is written through cfg_we_i/cfg_wdata_i; the user
// is to write it only while the block is idle, which the block itself does
// not enforce; it resets to 1000.
// depends on stb_pkg, stb_ctrl, stb_dpath and stb_ram
`default_nettype none

module software_timer_bank
  import stb_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  // register write port: min_interval_us
  input  wire logic                   cfg_we_i,
  input  wire logic [MIN_W-1:0]       cfg_wdata_i,

  // command beats
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // slot[3:0], interval_ms[25:4], owner_tag[41:26], mode_flags[44:42],
  // has_handler[45], now_us[77:46], zero fill [79:78]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // op[2:0]
  input  wire logic [OP_W-1:0]        s_axis_tuser,

  // result beats
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // timer_index[3:0], direct_call[4], event_owner[20:5], ok[21], zero fill [23:22]
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // kind[0]: 0 completion, 1 fire event
  output      logic                   m_axis_tuser,
  output      logic                   m_axis_tlast
);

  stb_cmd_t cmd;
  stb_sts_t sts;
  item_t    in_item;
  res_t     out_res;

  assign in_item = s_axis_tdata;

  // sequencing: one command at a time
  stb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot state, timer memory and the result register
  stb_dpath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_op_i     (s_axis_tuser),
    .in_item_i   (in_item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = out_res;

endmodule

`default_nettype wire

>>> src/stb_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module stb_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        raddr_i,
  output      logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/stb_ctrl.sv
// sequencing state machine of the timer bank
// depends on stb_pkg; drives stb_dpath through stb_cmd_t, reads stb_sts_t
`default_nettype none

module stb_ctrl
  import stb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output      logic     in_ready_o,
  input  wire stb_sts_t sts_i,
  output      stb_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_SCAN_RD  = 10'b00_0000_0100,
    S_SCAN_EV  = 10'b00_0000_1000,
    S_MUL      = 10'b00_0001_0000,
    S_CLAMP    = 10'b00_0010_0000,
    S_FIND     = 10'b00_0100_0000,
    S_CMD_RD   = 10'b00_1000_0000,
    S_CMD_WR   = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   done_ok_q, done_ok_d;
  isel_e  done_isel_q, done_isel_d;

  always_comb begin
    state_d     = state_q;
    done_ok_d   = done_ok_q;
    done_isel_d = done_isel_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (sts_i.op)
          OP_TICK: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_SCAN_RD;
          end
          OP_CREATE: begin
            if (sts_i.ms_zero) begin
              done_ok_d   = 1'b0;
              done_isel_d = IDX_ZERO;
              state_d     = S_DONE;
            end else begin
              state_d = S_MUL;
            end
          end
          OP_DESTROY, OP_STOP: begin
            if (sts_i.slot_valid) begin
              cmd_o.flag_op = (sts_i.op == OP_DESTROY) ? FL_DESTROY : FL_STOP;
            end
            done_ok_d   = sts_i.slot_valid;
            done_isel_d = IDX_SLOT;
            state_d     = S_DONE;
          end
          OP_START, OP_MODE: begin
            if (sts_i.slot_valid) begin
              state_d = S_CMD_RD;
            end else begin
              done_ok_d   = 1'b0;
              done_isel_d = IDX_SLOT;
              state_d     = S_DONE;
            end
          end
          default: begin
            done_ok_d   = 1'b0;
            done_isel_d = IDX_ZERO;
            state_d     = S_DONE;
          end
        endcase
      end

      S_SCAN_RD: begin
        cmd_o.ram_re   = 1'b1;
        cmd_o.ram_rsel = RA_CNT;
        state_d        = S_SCAN_EV;
      end

      S_SCAN_EV: begin
        // hold on a fire that finds the output register still full
        if (!(sts_i.scan_hit && sts_i.scan_notify && !sts_i.out_free)) begin
          if (sts_i.scan_hit) begin
            if (sts_i.scan_notify) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_fire = 1'b1;
              cmd_o.out_ok   = 1'b1;
              cmd_o.out_isel = IDX_CNT;
            end
            if (sts_i.scan_repeat) begin
              cmd_o.ram_we   = 1'b1;
              cmd_o.ram_wsel = WS_RELOAD;
            end else begin
              cmd_o.flag_op = FL_DISABLE;
            end
          end
          if (sts_i.cnt_last) begin
            done_ok_d   = 1'b1;
            done_isel_d = IDX_ZERO;
            state_d     = S_DONE;
          end else begin
            cmd_o.cnt_inc  = 1'b1;
            cmd_o.ram_re   = 1'b1;
            cmd_o.ram_rsel = RA_NEXT;
          end
        end
      end

      S_MUL: begin
        cmd_o.prod_load = 1'b1;
        cmd_o.cnt_clr   = 1'b1;
        state_d         = S_CLAMP;
      end

      S_CLAMP: begin
        cmd_o.ival_load = 1'b1;
        state_d         = S_FIND;
      end

      S_FIND: begin
        if (sts_i.cnt_free) begin
          cmd_o.ram_we   = 1'b1;
          cmd_o.ram_wsel = WS_CREATE;
          cmd_o.flag_op  = FL_CREATE;
          done_ok_d      = 1'b1;
          done_isel_d    = IDX_CNT;
          state_d        = S_DONE;
        end else if (sts_i.cnt_last) begin
          done_ok_d   = 1'b0;
          done_isel_d = IDX_ZERO;
          state_d     = S_DONE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end

      S_CMD_RD: begin
        cmd_o.ram_re   = 1'b1;
        cmd_o.ram_rsel = RA_SLOT;
        state_d        = S_CMD_WR;
      end

      S_CMD_WR: begin
        cmd_o.ram_wsel    = WS_RELOAD;
        cmd_o.ram_wa_slot = 1'b1;
        if (sts_i.op == OP_START) begin
          cmd_o.ram_we  = 1'b1;
          cmd_o.flag_op = FL_START;
        end else begin
          cmd_o.ram_we  = sts_i.mode_en;
          cmd_o.flag_op = FL_MODE;
        end
        done_ok_d   = 1'b1;
        done_isel_d = IDX_SLOT;
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ok   = done_ok_q;
          cmd_o.out_isel = done_isel_q;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_ok_q   <= 1'b0;
      done_isel_q <= IDX_ZERO;
    end else begin
      state_q     <= state_d;
      done_ok_q   <= done_ok_d;
      done_isel_q <= done_isel_d;
    end
  end

endmodule

`default_nettype wire

>>> src/stb_dpath.sv
// datapath of the timer bank: item registers, slot flags, timer memory,
// interval arithmetic and the output register; depends on stb_pkg and stb_ram
`default_nettype none

module stb_dpath
  import stb_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [MIN_W-1:0] cfg_wdata_i,
  input  wire logic [OP_W-1:0]  in_op_i,
  input  wire item_t            in_item_i,
  input  wire stb_cmd_t         cmd_i,
  output      stb_sts_t         sts_o,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      res_t             out_res_o,
  output      logic             out_kind_o,
  output      logic             out_last_o
);

  localparam int unsigned CNT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned XW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  // captured item
  logic [OP_W-1:0]    op_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [MS_W-1:0]    ms_q;
  logic [OWNER_W-1:0] owner_q;
  logic [MODE_W-1:0]  mode_q;
  logic               handler_q;
  logic [NOW_W-1:0]   now_q;

  logic [MIN_W-1:0]   min_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PROD_W-1:0]  prod_q;
  logic [IV_W-1:0]    ival_q;

  logic [TIMER_SLOTS-1:0] used_q, en_q, rep_q, dir_q, ntf_q;

  logic             out_valid_q;
  res_t             out_res_q;
  logic             out_kind_q;
  logic             out_last_q;

  logic [XW-1:0]    slot_ext;
  logic [CNT_W-1:0] sidx;
  logic [XW-1:0]    cnt_ext;
  logic [CNT_W-1:0] cnt_next;
  logic             slot_in_range;

  logic [ENTRY_W-1:0] rd_data, wr_data;
  logic [IV_W-1:0]    rd_iv;
  logic [OWNER_W-1:0] rd_owner;
  logic [NOW_W-1:0]   rd_start;
  logic [NOW_W-1:0]   elapsed;
  logic [CNT_W-1:0]   raddr, waddr;

  logic [PROD_W-1:0]  prod_d;
  logic [IV_W-1:0]    sat_iv, min_ext, ival_d;
  logic [SLOT_W-1:0]  idx_sel;

  assign slot_ext      = XW'(slot_q);
  assign sidx          = slot_ext[CNT_W-1:0];
  assign cnt_ext       = XW'(cnt_q);
  assign cnt_next      = cnt_q + CNT_W'(1);
  assign slot_in_range = ({3'b000, slot_q} < 7'(TIMER_SLOTS));

  // item capture and configuration register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= in_op_i;
      slot_q    <= in_item_i.slot;
      ms_q      <= in_item_i.interval_ms;
      owner_q   <= in_item_i.owner_tag;
      mode_q    <= in_item_i.mode_flags;
      handler_q <= in_item_i.has_handler;
      now_q     <= in_item_i.now_us;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_IV_RESET;
    end else if (cfg_we_i) begin
      min_q <= cfg_wdata_i;
    end
  end

  // slot counter shared by the tick scan and the free-slot search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_next;
    end
  end

  // ms to us, then saturate and clamp in the following cycle
  assign prod_d  = {10'b0, ms_q} * {22'b0, US_PER_MS};
  assign sat_iv  = prod_q[PROD_W-1] ? INTERVAL_MAX : prod_q[IV_W-1:0];
  assign min_ext = {11'b0, min_q};
  assign ival_d  = (sat_iv < min_ext) ? min_ext : sat_iv;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_load) begin
      prod_q <= prod_d;
    end
    if (cmd_i.ival_load) begin
      ival_q <= ival_d;
    end
  end

  // slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      en_q   <= '0;
      rep_q  <= '0;
      dir_q  <= '0;
      ntf_q  <= '0;
    end else begin
      case (cmd_i.flag_op)
        FL_CREATE: begin
          used_q[cnt_q] <= 1'b1;
          en_q[cnt_q]   <= mode_q[0];
          rep_q[cnt_q]  <= mode_q[1];
          dir_q[cnt_q]  <= mode_q[2];
          ntf_q[cnt_q]  <= handler_q;
        end
        FL_DESTROY: begin
          used_q[sidx] <= 1'b0;
          en_q[sidx]   <= 1'b0;
          rep_q[sidx]  <= 1'b0;
          dir_q[sidx]  <= 1'b0;
          ntf_q[sidx]  <= 1'b0;
        end
        FL_START: begin
          en_q[sidx] <= 1'b1;
        end
        FL_STOP: begin
          en_q[sidx] <= 1'b0;
        end
        FL_MODE: begin
          en_q[sidx]  <= mode_q[0];
          rep_q[sidx] <= mode_q[1];
          dir_q[sidx] <= mode_q[2];
        end
        FL_DISABLE: begin
          en_q[cnt_q] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // timer memory: interval, owner and start time per slot
  always_comb begin
    case (cmd_i.ram_rsel)
      RA_NEXT: raddr = cnt_next;
      RA_SLOT: raddr = sidx;
      default: raddr = cnt_q;
    endcase
  end

  assign waddr   = cmd_i.ram_wa_slot ? sidx : cnt_q;
  assign wr_data = (cmd_i.ram_wsel == WS_CREATE) ? {ival_q, owner_q, now_q}
                                                 : {rd_iv, rd_owner, now_q};

  stb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TIMER_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (waddr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.ram_re),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  assign rd_start = rd_data[NOW_W-1:0];
  assign rd_owner = rd_data[NOW_W+OWNER_W-1:NOW_W];
  assign rd_iv    = rd_data[ENTRY_W-1:NOW_W+OWNER_W];
  assign elapsed  = now_q - rd_start;

  // status back to the controller
  always_comb begin
    sts_o             = '0;
    sts_o.op          = op_q;
    sts_o.slot_valid  = slot_in_range && used_q[sidx];
    sts_o.ms_zero     = (ms_q == '0);
    sts_o.mode_en     = mode_q[0];
    sts_o.cnt_last    = (cnt_q == CNT_W'(TIMER_SLOTS - 1));
    sts_o.cnt_free    = !used_q[cnt_q];
    sts_o.scan_hit    = used_q[cnt_q] && en_q[cnt_q] && !elapsed[NOW_W-1]
                        && (elapsed[IV_W-1:0] >= rd_iv);
    sts_o.scan_notify = ntf_q[cnt_q];
    sts_o.scan_repeat = rep_q[cnt_q];
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // output register
  always_comb begin
    case (cmd_i.out_isel)
      IDX_SLOT: idx_sel = slot_q;
      IDX_CNT:  idx_sel = cnt_ext[SLOT_W-1:0];
      default:  idx_sel = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_res_q.pad         <= '0;
      out_res_q.ok          <= cmd_i.out_ok;
      out_res_q.timer_index <= idx_sel;
      out_res_q.direct_call <= cmd_i.out_fire && dir_q[cnt_q];
      out_res_q.event_owner <= cmd_i.out_fire ? rd_owner : '0;
      out_kind_q            <= cmd_i.out_fire;
      out_last_q            <= !cmd_i.out_fire;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> src/stb_checker.sv
// port-level checks for software_timer_bank, attached by bind
// depends on stb_pkg and on software_timer_bank's port names
`default_nettype none

module stb_checker
  import stb_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tuser,
  input wire logic                   m_axis_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // one command in flight: the input side drops ready after a beat
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while another is in flight");

  // fire beats never close a command, completions always do
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != m_axis_tlast))
    else $error("tlast does not match beat kind");

  // fire beats report ok
  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[21])
    else $error("fire beat without ok");

  // completions carry no owner and no direct flag
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[20:4] == '0))
    else $error("completion beat with owner or direct flag");

endmodule

bind software_timer_bank stb_checker u_stb_checker (.*);

`default_nettype wire

>>> sim/tb_software_timer_bank.sv
// testbench for software_timer_bank: directed and random command beats against a
// cycle-free model of the timer slots, results checked beat by beat
// depends on stb_pkg and software_timer_bank
`timescale 1ns / 100ps

module tb_software_timer_bank
  import stb_pkg::*;
();

  localparam int SLOTS = TIMER_SLOTS_DEF;

  // one result beat as the model predicts it
  typedef struct {
    bit        kind;
    bit [3:0]  idx;
    bit        direct;
    bit [15:0] owner;
    bit        ok;
    bit        last;
  } timer_beat_t;

  // slot table model plus the queue of beats it still expects
  class timer_bank_model;
    bit              used[SLOTS];
    bit              enabled[SLOTS];
    bit              repeat_on[SLOTS];
    bit              direct[SLOTS];
    bit              notify[SLOTS];
    bit [IV_W-1:0]   interval_us[SLOTS];
    bit [NOW_W-1:0]  start_us[SLOTS];
    bit [15:0]       owner[SLOTS];
    bit [MIN_W-1:0]  min_iv;
    timer_beat_t     pending_beats[$];
    int              errors;

    function new();
      min_iv = MIN_IV_RESET;
      errors = 0;
    endfunction

    function void push_beat(bit kind, bit [3:0] idx, bit dc, bit [15:0] own,
                            bit ok, bit last);
      timer_beat_t b;
      b.kind = kind;
      b.idx = idx;
      b.direct = dc;
      b.owner = own;
      b.ok = ok;
      b.last = last;
      pending_beats.push_back(b);
    endfunction

    // signed elapsed time against a non-negative interval
    function bit slot_due(int i, bit [31:0] now);
      bit [31:0] d;
      d = now - start_us[i];
      if (d[31])
        return 1'b0;
      return d >= {1'b0, interval_us[i]};
    endfunction

    function void note_command(bit [2:0] op, item_t it);
      bit [31:0] now;
      bit [3:0]  s;
      bit [63:0] us;
      bit        hit;
      int        k;
      int        i;
      now = it.now_us;
      s = it.slot;
      case (op)
        OP_TICK: begin
          for (i = 0; i < SLOTS; i++) begin
            if (used[i] && enabled[i] && slot_due(i, now)) begin
              if (notify[i])
                push_beat(1'b1, i[3:0], direct[i], owner[i], 1'b1, 1'b0);
              if (repeat_on[i])
                start_us[i] = now;
              else
                enabled[i] = 1'b0;
            end
          end
          push_beat(1'b0, 4'd0, 1'b0, 16'd0, 1'b1, 1'b1);
        end
        OP_CREATE: begin
          k = -1;
          for (i = SLOTS - 1; i >= 0; i--)
            if (!used[i])
              k = i;
          if (it.interval_ms == '0 || k < 0) begin
            push_beat(1'b0, 4'd0, 1'b0, 16'd0, 1'b0, 1'b1);
          end else begin
            us = 64'(it.interval_ms) * 64'(US_PER_MS);
            if (us > 64'(INTERVAL_MAX))
              us = 64'(INTERVAL_MAX);
            if (us < 64'(min_iv))
              us = 64'(min_iv);
            used[k] = 1'b1;
            enabled[k] = it.mode_flags[0];
            repeat_on[k] = it.mode_flags[1];
            direct[k] = it.mode_flags[2];
            notify[k] = it.has_handler;
            interval_us[k] = us[IV_W-1:0];
            start_us[k] = now;
            owner[k] = it.owner_tag;
            push_beat(1'b0, k[3:0], 1'b0, 16'd0, 1'b1, 1'b1);
          end
        end
        OP_DESTROY, OP_START, OP_STOP, OP_MODE: begin
          hit = used[s];
          if (hit) begin
            case (op)
              OP_DESTROY: begin
                used[s] = 1'b0;
                enabled[s] = 1'b0;
                repeat_on[s] = 1'b0;
                direct[s] = 1'b0;
                notify[s] = 1'b0;
              end
              OP_START: begin
                start_us[s] = now;
                enabled[s] = 1'b1;
              end
              OP_STOP: begin
                enabled[s] = 1'b0;
              end
              default: begin
                enabled[s] = it.mode_flags[0];
                repeat_on[s] = it.mode_flags[1];
                direct[s] = it.mode_flags[2];
                if (it.mode_flags[0])
                  start_us[s] = now;
              end
            endcase
          end
          push_beat(1'b0, s, 1'b0, 16'd0, hit, 1'b1);
        end
        default: begin
          push_beat(1'b0, 4'd0, 1'b0, 16'd0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    task report(string what, longint got, longint want);
      if (errors < 40)
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_beat(bit kind, bit last, res_t r);
      timer_beat_t b;
      if (pending_beats.size() == 0) begin
        report("beat with nothing pending, index", r.timer_index, 0);
        return;
      end
      b = pending_beats.pop_front();
      if (kind != b.kind)
        report("kind", kind, b.kind);
      if (r.timer_index != b.idx)
        report("timer_index", r.timer_index, b.idx);
      if (r.direct_call != b.direct)
        report("direct_call", r.direct_call, b.direct);
      if (r.event_owner != b.owner)
        report("event_owner", r.event_owner, b.owner);
      if (r.ok != b.ok)
        report("ok", r.ok, b.ok);
      if (last != b.last)
        report("last", last, b.last);
    endtask

    function int pending();
      return pending_beats.size();
    endfunction

    // a random slot that is in use, or -1 when the table is empty
    function int pick_used();
      int list[$];
      int i;
      for (i = 0; i < SLOTS; i++)
        if (used[i])
          list.push_back(i);
      if (list.size() == 0)
        return -1;
      return list[$urandom_range(0, list.size() - 1)];
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [MIN_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  timer_bank_model model = new();

  bit        burst;      // both sides stop idling while set
  int        hold_req;   // cycles the result side is asked to hold off
  bit [31:0] clock_us;   // free-running microsecond time seen by the block
  int        step_max;   // largest time advance between two commands

  software_timer_bank DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // offer one command beat after a random gap; tvalid stays high when the gap is zero
  task send_command(bit [2:0] op, item_t it);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it;
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    model.note_command(op, it);
  endtask

  task cmd(bit [2:0] op, bit [3:0] slot, bit [21:0] ms, bit [15:0] own,
           bit [2:0] mode, bit hnd, bit [31:0] now);
    item_t it;
    it = '0;
    it.slot = slot;
    it.interval_ms = ms;
    it.owner_tag = own;
    it.mode_flags = mode;
    it.has_handler = hnd;
    it.now_us = now;
    send_command(op, it);
  endtask

  // stop offering and wait for every pending beat, then let the block settle
  task drain();
    s_axis_tvalid <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task write_min_interval(bit [MIN_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model.min_iv = v;
  endtask

  // mostly well-formed commands on slots that are in use, with some noise
  task random_command();
    item_t   it;
    bit [2:0] op;
    int      r;
    int      k;
    it = '0;
    clock_us += $urandom_range(0, step_max);
    // now and then a time far from the running clock: negative or huge elapsed
    it.now_us = ($urandom_range(0, 24) == 0) ? $urandom() : clock_us;
    it.slot = SLOT_W'($urandom());
    it.interval_ms = MS_W'($urandom());
    it.owner_tag = OWNER_W'($urandom());
    it.mode_flags = MODE_W'($urandom());
    if ($urandom_range(0, 3) != 0)
      it.mode_flags[0] = 1'b1;
    it.has_handler = ($urandom_range(0, 4) != 0);
    r = $urandom_range(0, 99);
    if (r < 35) begin
      op = OP_TICK;
    end else if (r < 55) begin
      op = OP_CREATE;
      case ($urandom_range(0, 19))
        0:       it.interval_ms = '0;
        1, 2:    it.interval_ms = MS_W'($urandom());
        3:       it.interval_ms = MS_W'($urandom_range(2147483, 2147484));
        default: it.interval_ms = MS_W'($urandom_range(1, 4));
      endcase
    end else if (r < 92) begin
      if (r < 63)
        op = OP_DESTROY;
      else if (r < 73)
        op = OP_START;
      else if (r < 80)
        op = OP_STOP;
      else
        op = OP_MODE;
      k = model.pick_used();
      if (k >= 0 && $urandom_range(0, 6) != 0)
        it.slot = SLOT_W'(k);
    end else if (r < 96) begin
      op = OP_W'($urandom_range(6, 7));
    end else begin
      op = OP_W'($urandom());
    end
    send_command(op, it);
  endtask

  // one setting of min_interval_us; hold_at starts a long result stall,
  // pause_at makes the sender wait until the block has emptied
  task run_phase(bit [MIN_W-1:0] min_v, int count, int hold_at, int pause_at);
    int i;
    drain();
    write_min_interval(min_v);
    step_max = (min_v > 4000) ? int'(min_v) / 2 : 1500;
    for (i = 0; i < count; i++) begin
      burst = (i >= 20 && i < 40);
      if (i == hold_at)
        hold_req = 300;
      if (i == pause_at)
        drain();
      random_command();
    end
    burst = 1'b0;
  endtask

  // result side: random tready gaps, one long hold when asked
  initial begin : result_sink
    int gap;
    int n;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      gap = burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      model.check_beat(m_axis_tuser, m_axis_tlast, res_t'(m_axis_tdata));
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    burst = 1'b0;
    hold_req = 0;
    clock_us = '0;
    step_max = 1500;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset value of min_interval_us
    cmd(OP_TICK, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd0);              // empty table
    cmd(OP_CREATE, 4'd0, 22'd0, 16'hFFFF, 3'b011, 1'b1, 32'd50);        // zero interval
    cmd(OP_CREATE, 4'd0, 22'd1, 16'hFFFF, 3'b011, 1'b1, 32'd100);       // slot 0, 1 ms repeat
    cmd(OP_CREATE, 4'd0, 22'h3FFFFF, 16'h0000, 3'b111, 1'b1, 32'd200);  // saturates
    cmd(OP_CREATE, 4'd0, 22'd2147483, 16'h1234, 3'b101, 1'b0, 32'd300); // top of range
    cmd(OP_DESTROY, 4'd15, 22'd0, 16'd0, 3'b000, 1'b0, 32'd400);        // unused slots
    cmd(OP_START, 4'd14, 22'd0, 16'd0, 3'b000, 1'b0, 32'd400);
    cmd(OP_STOP, 4'd13, 22'd0, 16'd0, 3'b000, 1'b0, 32'd400);
    cmd(OP_MODE, 4'd12, 22'd0, 16'd0, 3'b111, 1'b0, 32'd400);
    cmd(3'd6, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd400);               // unknown ops
    cmd(3'd7, 4'hF, 22'h3FFFFF, 16'hFFFF, 3'b111, 1'b1, 32'hFFFF_FFFF);
    cmd(OP_TICK, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd1099);           // one short of due
    cmd(OP_TICK, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd1100);           // fires, reloads
    cmd(OP_MODE, 4'd0, 22'd0, 16'd0, 3'b101, 1'b0, 32'd1200);           // direct, one-shot
    cmd(OP_TICK, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd2200);           // fires, disables
    cmd(OP_TICK, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd5000);
    cmd(OP_START, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd5000);
    cmd(OP_STOP, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd5100);
    cmd(OP_TICK, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd9000);
    cmd(OP_START, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd10000);
    cmd(OP_TICK, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'h9000_0000);      // negative elapsed
    cmd(OP_DESTROY, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd11000);
    cmd(OP_CREATE, 4'd0, 22'd2, 16'h00A5, 3'b010, 1'b1, 32'd11000);     // reuses slot 0
    cmd(OP_MODE, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd12000);          // disabled mode
    cmd(OP_TICK, 4'd0, 22'd0, 16'd0, 3'b000, 1'b0, 32'd20000);

    // random phases over several register settings, first one across the time wrap
    clock_us = 32'hFFFF_0000;
    run_phase(20'd1, 100, 50, -1);
    run_phase(20'hFFFFF, 80, -1, 40);
    run_phase(20'd0, 60, -1, -1);
    run_phase(MIN_W'($urandom_range(1, 1000000)), 100, 70, -1);
    run_phase(20'd1000000, 80, -1, 30);

    drain();
    repeat (32) @(posedge clk_i);
    if (model.errors == 0 && model.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
